/* sv/vgss_pkg.sv */
package vgss_pkg;

    // Frame geometry.
    localparam int DOT_GROUPS  = 39;
    localparam int GRID_LIMIT  = 52;
    localparam int GRID_BITS   = GRID_LIMIT + 2;
    localparam int GROUP_BITS  = 6;
    localparam int CHUNK_W     = 48;
    localparam int CHUNK_COUNT = 6;

    // The frame store is kept as rows of eight bytes, one row for each of the first five chunks.
    localparam int LANES     = CHUNK_W / GROUP_BITS;
    localparam int ROWS      = (DOT_GROUPS + LANES - 1) / LANES;
    localparam int LANE_W    = $clog2(LANES);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int SLOTS     = ROWS * LANES;
    localparam int IDX_W     = 6;
    localparam int GRID_W    = 6;
    localparam int K_W       = 3;

    // Chunk numbers with a special layout.
    localparam logic [K_W-1:0] K_MIXED = K_W'(ROWS - 1);
    localparam logic [K_W-1:0] K_LAST  = K_W'(CHUNK_COUNT - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    localparam logic [GRID_W-1:0] GRID_FIRST = GRID_W'(1);
    localparam logic [GRID_W-1:0] GRID_LAST  = GRID_W'(GRID_LIMIT);
    localparam logic [IDX_W-1:0]  IDX_LIMIT  = IDX_W'(DOT_GROUPS);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_kind_t;

    // One entry of the queue between the front and the back.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [7:0]        value;
        logic [GRID_W-1:0] grid;
    } cmd_t;

    // Handshake bundle from the back toward the queue.
    typedef struct packed {
        logic pop;
    } q_ctrl_t;

    // Six bits of one dot group in send order, the first-sent bit at bit 5.
    function automatic logic [GROUP_BITS-1:0] dot_group(input logic [7:0] b,
                                                       input logic odd);
        logic [GROUP_BITS-1:0] g;
        if (odd)
        begin
            g = {b[7], b[0], b[6], b[0], b[5], b[0]};
        end
        else
        begin
            g = {b[0], b[2], b[0], b[3], b[0], b[4]};
        end
        return g;
    endfunction

    // Grid select bits in send order: position p sits at bit GRID_BITS - p.
    function automatic logic [GRID_BITS-1:0] grid_seq(input logic [GRID_W-1:0] n);
        logic [GRID_W-1:0] sh;
        sh = GRID_W'(GRID_BITS - 1) - n;
        return {{(GRID_BITS-2){1'b0}}, 2'b11} << sh;
    endfunction

endpackage

/* sv/vgss_if.sv */
interface vgss_in_if import vgss_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             func;
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       byte_value;

    modport source (output valid, output func, output byte_index, output byte_value,
                    input ready);
    modport sink   (input valid, input func, input byte_index, input byte_value,
                    output ready);
endinterface

interface vgss_out_if import vgss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] chunk_bits;
    logic               latch_pulse;
    logic               last_chunk;

    modport source (output valid, output chunk_bits, output latch_pulse,
                    output last_chunk, input ready);
    modport sink   (input valid, input chunk_bits, input latch_pulse,
                    input last_chunk, output ready);
endinterface

/* sv/vgss_front.sv */
module vgss_front import vgss_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    vgss_in_if.sink items,
    input  logic q_full,
    output logic push,
    output cmd_t push_cmd
);

    logic [GRID_W-1:0] grid_reg;
    logic [GRID_W-1:0] grid_next;
    logic [GRID_W-1:0] grid_use;
    logic              accept;

    assign items.ready = !q_full;
    assign accept      = items.valid && items.ready;

    // A grid number outside the legal range is taken as the first grid.
    assign grid_use = (grid_reg < GRID_FIRST || grid_reg > GRID_LAST) ? GRID_FIRST
                                                                       : grid_reg;

    always_comb
    begin
        grid_next = grid_reg;
        if (accept && items.func)
        begin
            grid_next = (grid_use == GRID_LAST) ? GRID_FIRST : grid_use + GRID_W'(1);
        end
    end

    // Writes beyond the store are dropped here and never reach the queue.
    always_comb
    begin
        push_cmd.kind  = items.func ? CMD_TICK : CMD_WRITE;
        push_cmd.idx   = items.byte_index;
        push_cmd.value = items.byte_value;
        push_cmd.grid  = grid_use;
        push = accept && (items.func || items.byte_index < IDX_LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= GRID_FIRST;
        end
        else
        begin
            grid_reg <= grid_next;
        end
    end

endmodule

/* sv/vgss_fifo.sv */
module vgss_fifo import vgss_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  q_ctrl_t ctrl,
    output logic    full,
    output logic    empty,
    output cmd_t    head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign full   = (count_reg == 2'd2);
    assign empty  = (count_reg == 2'd0);
    assign head   = slot_reg[rd_ptr_reg];
    assign do_pop = ctrl.pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* sv/vgss_back.sv */
module vgss_back import vgss_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  cmd_t    head,
    output q_ctrl_t ctrl,
    vgss_out_if.source chunks
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t            state_reg;
    logic [GRID_W-1:0] n_reg;
    logic [K_W-1:0]    k_reg;

    // Frame store: one row for each of the first five chunks, one byte lane per dot group.
    logic [LANES-1:0][7:0] mem_reg [ROWS];
    logic [SLOTS-1:0]      filled_reg;

    // Read stage.
    logic                  a_valid_reg;
    logic [LANES-1:0][7:0] a_row_reg;
    logic [LANES-1:0]      a_mask_reg;
    logic [K_W-1:0]        a_k_reg;
    logic [GRID_W-1:0]     a_n_reg;

    // Output register.
    logic               o_valid_reg;
    logic [CHUNK_W-1:0] o_chunk_reg;
    logic               o_latch_reg;
    logic               o_last_reg;

    logic               take;
    logic               a_move;
    logic               issue;
    logic [ROW_W-1:0]   rd_row;
    logic [ROW_W-1:0]   wr_row;
    logic [LANE_W-1:0]  wr_lane;
    logic               do_write;
    logic [CHUNK_W-1:0] chunk;
    logic [GRID_BITS-1:0] gseq;
    logic [7:0]         lane_byte;

    assign take   = !o_valid_reg || chunks.ready;
    assign a_move = a_valid_reg && take;
    assign issue  = (state_reg == ST_RUN) && (!a_valid_reg || a_move);

    assign ctrl.pop = (state_reg == ST_IDLE);
    assign do_write = (state_reg == ST_IDLE) && !q_empty && (head.kind == CMD_WRITE);
    assign wr_row   = head.idx[LANE_W +: ROW_W];
    assign wr_lane  = head.idx[LANE_W-1:0];
    assign rd_row   = (k_reg > K_W'(ROW_LAST)) ? ROW_LAST : k_reg[ROW_W-1:0];

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem_reg[wr_row][wr_lane] <= head.value;
        end
        if (issue)
        begin
            a_row_reg  <= mem_reg[rd_row];
            a_mask_reg <= filled_reg[{rd_row, {LANE_W{1'b0}}} +: LANES];
            a_k_reg    <= k_reg;
            a_n_reg    <= n_reg;
        end
        if (a_move)
        begin
            o_chunk_reg <= chunk;
            o_latch_reg <= (a_k_reg == '0);
            o_last_reg  <= (a_k_reg == K_LAST);
        end
    end

    // Chunk assembly: eight dot groups, except that the fifth chunk ends in the
    // first grid bits and the sixth carries the remaining grid bits only.
    always_comb
    begin
        gseq  = grid_seq(a_n_reg);
        chunk = '0;
        for (int j = 0; j < LANES; j++)
        begin
            lane_byte = a_mask_reg[j] ? a_row_reg[j] : 8'h00;
            chunk[CHUNK_W-1-GROUP_BITS*j -: GROUP_BITS] = dot_group(lane_byte, a_n_reg[0]);
        end
        if (a_k_reg == K_MIXED)
        begin
            chunk[GROUP_BITS-1:0] = gseq[GRID_BITS-1 -: GROUP_BITS];
        end
        else if (a_k_reg == K_LAST)
        begin
            chunk = gseq[CHUNK_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= GRID_FIRST;
            k_reg       <= '0;
            filled_reg  <= '0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_write)
            begin
                filled_reg[head.idx] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty && head.kind == CMD_TICK)
                    begin
                        state_reg <= ST_RUN;
                        n_reg     <= head.grid;
                        k_reg     <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        k_reg <= k_reg + K_W'(1);
                        if (k_reg == K_LAST)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (issue)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (chunks.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    assign chunks.valid       = o_valid_reg;
    assign chunks.chunk_bits  = o_chunk_reg;
    assign chunks.latch_pulse = o_latch_reg;
    assign chunks.last_chunk  = o_last_reg;

endmodule

/* sv/vfd_grid_scan_serializer_unit.sv */
// Refresh serializer for a multiplexed dot display.
// The items channel carries two kinds of transaction. With func low, a
// transaction stores byte_value at byte_index of the 39-byte frame store;
// an index of 39 or more is accepted and dropped. With func high, it is a
// refresh tick for the current grid, which then advances from 52 back to 1.
// Each tick produces six transactions on the chunks channel, 48 frame bits
// each with the first-sent bit in the MSB. latch_pulse marks the first
// chunk and last_chunk the sixth.
// Timing: an accepted tick passes through the queue, the back end's command
// capture, the read stage and the output register before its first chunk
// appears, and the six chunks follow on consecutive cycles while the receiver
// is ready. A tick occupies the back end for one frame store row read per
// chunk plus the step that takes the command; a write only for that step.
// A two-entry command queue separates the input side from the chunk
// builder, so the input can accept up to two transactions while chunks drain.
// When the receiver stalls, the output register holds its chunk, the row
// read behind it waits, and the queue fills and then lowers ready.
// Reset empties the queue and the pipeline, marks every stored byte as
// zero through per-byte fill flags, and sets the grid number to 1.
module vfd_grid_scan_serializer_unit import vgss_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    vgss_in_if.sink    items,
    vgss_out_if.source chunks
);

    logic    q_full;
    logic    q_empty;
    logic    push;
    cmd_t    push_cmd;
    cmd_t    head;
    q_ctrl_t ctrl;

    // Front end: accepts transactions, screens write indexes and stamps each
    // tick with its grid number.
    vgss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue; writes and ticks stay in order so a write that follows
    // a tick never alters that tick's frame.
    vgss_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .ctrl     (ctrl),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Back end: owns the frame store, reads one row per chunk and builds the
    // chunk into the output register.
    vgss_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .ctrl    (ctrl),
        .chunks  (chunks)
    );

endmodule
